>>> rtl/ppe_pkg.sv
// Shared types, constants and helper functions of the particle pool engine.
`default_nettype none
package ppe_pkg;

   localparam int POOL_SIZE_DEF = 64;
   localparam int SLOT_W = 6;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] MODE_EMIT = 2'd0;
   localparam logic [1:0] MODE_TICK = 2'd1;
   localparam logic [1:0] MODE_RENDER = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_LIFE_TIME = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_BEGIN = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_END = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_VAR = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_VAR_X = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_VAR_Y = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_BEGIN = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_END = 4'd7;

   localparam logic [31:0] LIFE_TIME_RST = 32'd65536;
   localparam logic [30:0] SIZE_BEGIN_RST = 31'd65536;
   localparam logic [30:0] SIZE_END_RST = 31'd0;
   localparam logic [30:0] SIZE_VAR_RST = 31'd0;
   localparam logic [30:0] VEL_VAR_RST = 31'd0;
   localparam logic [31:0] COLOR_BEGIN_RST = 32'hFFFF_FFFF;
   localparam logic [31:0] COLOR_END_RST = 32'h0000_0000;

   // Unity in the Q1.16 life fraction.
   localparam logic [16:0] FRAC_ONE = 17'd65536;
   // ceil(2^32 / 100); exact floor division for operands below 2^26.
   localparam logic [25:0] RECIP_100 = 26'd42949673;
   localparam logic [25:0] TWO_PI_X100 = 26'd628;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_vx;
      logic signed [31:0] start_vy;
      logic [15:0]        rand_angle;
      logic [15:0]        rand_vx;
      logic [15:0]        rand_vy;
      logic [15:0]        rand_size;
      logic [19:0]        time_step;
   } req_type;

   typedef struct packed {
      logic signed [31:0] draw_x;
      logic signed [31:0] draw_y;
      logic signed [31:0] draw_rotation;
      logic signed [31:0] draw_size;
      logic [31:0]        draw_color;
      logic [SLOT_W-1:0]  slot;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic [31:0]        rotation;
      logic [31:0]        life;
      logic signed [31:0] size;
   } entry_type;

   typedef struct packed {
      logic        start;
      logic [31:0] life;
      logic [31:0] life_time;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [16:0] frac;
   } div_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647) r = 32'sh7FFF_FFFF;
      else if (v < -40'sd2147483648) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic [19:0] div100(input logic [25:0] x);
      logic [51:0] p;
      p = 52'(x) * 52'(RECIP_100);
      return p[51:32];
   endfunction

endpackage
`default_nettype wire

>>> rtl/ppe_stream_if.sv
// Valid/ready stream channel carrying one word of a given payload type.
`default_nettype none
interface ppe_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/ppe_div.sv
// Life fraction divider: min(1, life / life_time) in Q1.16, two quotient bits a cycle.
`default_nettype none
module ppe_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ppe_pkg::div_req_type div_req,
   output ppe_pkg::div_rsp_type      div_rsp
);
   localparam int BITS_PER_STEP = 2;
   localparam int STEPS = 16 / BITS_PER_STEP;
   localparam int STEP_W = $clog2(STEPS);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [31:0]       rem_ff;
   logic [31:0]       dvs_ff;
   logic [16:0]       quo_ff;
   logic [31:0]       rem_in;
   logic [16:0]       quo_in;
   logic [32:0]       trial;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      trial = '0;
      for (int k = 0; k < BITS_PER_STEP; k++) begin
         trial = {rem_in, 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 32'(trial - {1'b0, dvs_ff});
            quo_in = {quo_in[15:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_in[15:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            // A zero lifetime gives a zero fraction; a life at or above it saturates to one.
            if (div_req.life_time == '0 || div_req.life >= div_req.life_time) begin
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
               step_ff <= '0;
            end
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= div_req.life;
         dvs_ff <= div_req.life_time;
         if (div_req.life_time == '0) quo_ff <= '0;
         else if (div_req.life >= div_req.life_time) quo_ff <= ppe_pkg::FRAC_ONE;
         else quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.frac = quo_ff;
endmodule
`default_nettype wire

>>> rtl/particle_pool_engine_top.sv
// Particle pool engine: one slot memory written by emit and tick words, read by render.
// Emit: a jitter multiply state, then a write state, before the next word is taken. Tick:
// the slot memory is walked one slot a cycle through a read, multiply and write-back
// pipeline. Render: the scan skips inactive slots; active ones pass the read, divide,
// multiply, add and output states, output waiting out result stalls. Reset clears the
// active flags and presets emit index and configuration; slot contents stay undefined.
`default_nettype none
module particle_pool_engine_top #(
   parameter int POOL_SIZE = ppe_pkg::POOL_SIZE_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   ppe_stream_if.sink                           req_chan,
   ppe_stream_if.source                         rsp_chan,
   input  wire logic                            csr_we,
   input  wire logic [ppe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ppe_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int CNT_W = $clog2(POOL_SIZE + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SIZE - 1);
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(POOL_SIZE);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_EMIT_MUL = 4'd1;
   localparam logic [3:0] ST_EMIT_WR = 4'd2;
   localparam logic [3:0] ST_TICK_PREP = 4'd3;
   localparam logic [3:0] ST_TICK_RUN = 4'd4;
   localparam logic [3:0] ST_R_SCAN = 4'd5;
   localparam logic [3:0] ST_R_READ = 4'd6;
   localparam logic [3:0] ST_R_DIV = 4'd7;
   localparam logic [3:0] ST_R_MUL = 4'd8;
   localparam logic [3:0] ST_R_ADD = 4'd9;
   localparam logic [3:0] ST_R_OUT = 4'd10;

   // Configuration registers
   logic [31:0] life_time_ff;
   logic [30:0] size_begin_ff;
   logic [30:0] size_end_ff;
   logic [30:0] size_var_ff;
   logic [30:0] vel_var_x_ff;
   logic [30:0] vel_var_y_ff;
   logic [31:0] color_begin_ff;
   logic [31:0] color_end_ff;

   // Control
   logic [3:0]           state_ff;
   logic [3:0]           state_in;
   ppe_pkg::req_type     req_ff;
   logic [CNT_W-1:0]     idx_ff;
   logic [IDX_W-1:0]     emit_slot_ff;
   logic [POOL_SIZE-1:0] active_ff;
   logic                 req_fire;
   logic                 idx_in_range;
   logic [IDX_W-1:0]     idx_slot;
   logic                 idx_active;

   // Slot memory
   ppe_pkg::entry_type pool_mem [POOL_SIZE];
   ppe_pkg::entry_type rd_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   ppe_pkg::entry_type mem_wdata;

   // Emit datapath
   logic signed [48:0] jit_vx_ff;
   logic signed [48:0] jit_vy_ff;
   logic signed [48:0] jit_size_ff;
   logic [25:0]        rot_x_ff;
   ppe_pkg::entry_type emit_entry;

   // Tick datapath
   logic [19:0]        dtdiv_ff;
   logic               tb_vld_ff;
   logic [IDX_W-1:0]   tb_idx_ff;
   logic               tc_vld_ff;
   logic [IDX_W-1:0]   tc_idx_ff;
   logic signed [52:0] tc_px_ff;
   logic signed [52:0] tc_py_ff;
   ppe_pkg::entry_type tc_entry_ff;
   ppe_pkg::entry_type tc_entry_in;
   ppe_pkg::entry_type tick_entry;
   logic               tick_issue;
   logic               tb_dead;
   logic [31:0]        dt32;

   // Render datapath
   ppe_pkg::div_req_type div_req;
   ppe_pkg::div_rsp_type div_rsp;
   logic [16:0]          frac_ff;
   logic signed [17:0]   age;
   logic signed [32:0]   size_diff;
   logic signed [50:0]   sz_prod_ff;
   logic signed [26:0]   ch_prod_ff [4];
   logic signed [31:0]   size_lerp_ff;
   logic [7:0]           ch_ff [4];
   logic signed [11:0]   ch_sum [4];
   logic [24:0]          alpha_prod;
   logic [POOL_SIZE-1:0] above_mask;
   logic                 is_last;
   logic                 rsp_vld_ff;
   ppe_pkg::rsp_type     rsp_data_ff;
   logic                 rsp_load;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign idx_in_range = (idx_ff < CNT_END);
   assign idx_slot = idx_in_range ? idx_ff[IDX_W-1:0] : '0;
   assign idx_active = idx_in_range && active_ff[idx_slot];
   assign dt32 = 32'(req_ff.time_step);

   always_ff @(posedge clock) begin
      if (reset) begin
         life_time_ff <= ppe_pkg::LIFE_TIME_RST;
         size_begin_ff <= ppe_pkg::SIZE_BEGIN_RST;
         size_end_ff <= ppe_pkg::SIZE_END_RST;
         size_var_ff <= ppe_pkg::SIZE_VAR_RST;
         vel_var_x_ff <= ppe_pkg::VEL_VAR_RST;
         vel_var_y_ff <= ppe_pkg::VEL_VAR_RST;
         color_begin_ff <= ppe_pkg::COLOR_BEGIN_RST;
         color_end_ff <= ppe_pkg::COLOR_END_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            ppe_pkg::CSR_LIFE_TIME: life_time_ff <= csr_wdata;
            ppe_pkg::CSR_SIZE_BEGIN: size_begin_ff <= csr_wdata[30:0];
            ppe_pkg::CSR_SIZE_END: size_end_ff <= csr_wdata[30:0];
            ppe_pkg::CSR_SIZE_VAR: size_var_ff <= csr_wdata[30:0];
            ppe_pkg::CSR_VEL_VAR_X: vel_var_x_ff <= csr_wdata[30:0];
            ppe_pkg::CSR_VEL_VAR_Y: vel_var_y_ff <= csr_wdata[30:0];
            ppe_pkg::CSR_COLOR_BEGIN: color_begin_ff <= csr_wdata;
            ppe_pkg::CSR_COLOR_END: color_end_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               priority if (req_chan.payload.mode == ppe_pkg::MODE_EMIT) state_in = ST_EMIT_MUL;
               else if (req_chan.payload.mode == ppe_pkg::MODE_TICK) state_in = ST_TICK_PREP;
               else if (req_chan.payload.mode == ppe_pkg::MODE_RENDER) state_in = ST_R_SCAN;
               else state_in = ST_IDLE;
            end
         end
         ST_EMIT_MUL: state_in = ST_EMIT_WR;
         ST_EMIT_WR: state_in = ST_IDLE;
         ST_TICK_PREP: state_in = ST_TICK_RUN;
         ST_TICK_RUN: begin
            if (!idx_in_range && !tb_vld_ff && !tc_vld_ff) state_in = ST_IDLE;
         end
         ST_R_SCAN: begin
            if (!idx_in_range) state_in = ST_IDLE;
            else if (idx_active) state_in = ST_R_READ;
         end
         ST_R_READ: state_in = ST_R_DIV;
         ST_R_DIV: if (div_rsp.done) state_in = ST_R_MUL;
         ST_R_MUL: state_in = ST_R_ADD;
         ST_R_ADD: state_in = ST_R_OUT;
         ST_R_OUT: if (rsp_load) state_in = ST_R_SCAN;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
         emit_slot_ff <= LAST_IDX;
         tb_vld_ff <= 1'b0;
         tc_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_fire) idx_ff <= '0;
         else if (state_ff == ST_TICK_RUN && idx_in_range) idx_ff <= idx_ff + 1'b1;
         else if (state_ff == ST_R_SCAN && idx_in_range && !idx_active) idx_ff <= idx_ff + 1'b1;
         else if (state_ff == ST_R_OUT && rsp_load) idx_ff <= idx_ff + 1'b1;
         if (state_ff == ST_EMIT_WR)
            emit_slot_ff <= (emit_slot_ff == '0) ? LAST_IDX : emit_slot_ff - 1'b1;
         tb_vld_ff <= tick_issue;
         tc_vld_ff <= tb_vld_ff && !tb_dead;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) req_ff <= req_chan.payload;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else begin
         if (state_ff == ST_EMIT_WR) active_ff[emit_slot_ff] <= 1'b1;
         if (tb_dead) active_ff[tb_idx_ff] <= 1'b0;
      end
   end

   // Slot memory: one write and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) pool_mem[mem_waddr] <= mem_wdata;
      rd_ff <= pool_mem[idx_slot];
   end

   // Emit: jitter products first, then sums, saturation and the write.
   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT_MUL) begin
         jit_vx_ff <= $signed({1'b0, vel_var_x_ff})
                      * ($signed({1'b0, req_ff.rand_vx}) - 17'sd32768);
         jit_vy_ff <= $signed({1'b0, vel_var_y_ff})
                      * ($signed({1'b0, req_ff.rand_vy}) - 17'sd32768);
         jit_size_ff <= $signed({1'b0, size_var_ff})
                        * ($signed({1'b0, req_ff.rand_size}) - 17'sd32768);
         rot_x_ff <= 26'(req_ff.rand_angle) * ppe_pkg::TWO_PI_X100;
      end
   end

   always_comb begin
      emit_entry.pos_x = req_ff.start_x;
      emit_entry.pos_y = req_ff.start_y;
      emit_entry.vel_x = ppe_pkg::sat32(40'(req_ff.start_vx) + 40'($signed(jit_vx_ff[48:16])));
      emit_entry.vel_y = ppe_pkg::sat32(40'(req_ff.start_vy) + 40'($signed(jit_vy_ff[48:16])));
      emit_entry.rotation = 32'(ppe_pkg::div100(rot_x_ff));
      emit_entry.life = life_time_ff;
      emit_entry.size = ppe_pkg::sat32(40'($signed({1'b0, size_begin_ff}))
                                       + 40'($signed(jit_size_ff[48:16])));
   end

   // Tick pipeline: read, then multiply, then add and write back. Three different
   // slots are in flight, so a write never meets a read of the same slot.
   assign tick_issue = (state_ff == ST_TICK_RUN) && idx_active;
   assign tb_dead = tb_vld_ff && (rd_ff.life == '0);

   always_comb begin
      tc_entry_in = rd_ff;
      tc_entry_in.life = (rd_ff.life > dt32) ? rd_ff.life - dt32 : '0;
      tc_entry_in.rotation = rd_ff.rotation + 32'(dtdiv_ff);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_TICK_PREP) dtdiv_ff <= ppe_pkg::div100(26'(req_ff.time_step));
      tb_idx_ff <= idx_slot;
      tc_idx_ff <= tb_idx_ff;
      tc_px_ff <= rd_ff.vel_x * $signed({1'b0, req_ff.time_step});
      tc_py_ff <= rd_ff.vel_y * $signed({1'b0, req_ff.time_step});
      tc_entry_ff <= tc_entry_in;
   end

   always_comb begin
      tick_entry = tc_entry_ff;
      tick_entry.pos_x = ppe_pkg::sat32(40'(tc_entry_ff.pos_x) + 40'($signed(tc_px_ff[52:16])));
      tick_entry.pos_y = ppe_pkg::sat32(40'(tc_entry_ff.pos_y) + 40'($signed(tc_py_ff[52:16])));
   end

   always_comb begin
      if (state_ff == ST_EMIT_WR) begin
         mem_we = 1'b1;
         mem_waddr = emit_slot_ff;
         mem_wdata = emit_entry;
      end else begin
         mem_we = tc_vld_ff;
         mem_waddr = tc_idx_ff;
         mem_wdata = tick_entry;
      end
   end

   // Render: the slot word in rd_ff stays put while the slot index is held.
   assign div_req.start = (state_ff == ST_R_READ);
   assign div_req.life = rd_ff.life;
   assign div_req.life_time = life_time_ff;

   ppe_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign age = 18'sd65536 - $signed({1'b0, frac_ff});
   assign size_diff = $signed({2'b00, size_end_ff}) - 33'(rd_ff.size);

   always_comb begin
      for (int k = 0; k < 4; k++)
         ch_sum[k] = $signed({4'b0000, color_begin_ff[8*k +: 8]})
                     + 12'($signed(ch_prod_ff[k][26:16]));
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_R_DIV && div_rsp.done) frac_ff <= div_rsp.frac;
      if (state_ff == ST_R_MUL) begin
         sz_prod_ff <= size_diff * age;
         for (int k = 0; k < 4; k++)
            ch_prod_ff[k] <= ($signed({1'b0, color_end_ff[8*k +: 8]})
                              - $signed({1'b0, color_begin_ff[8*k +: 8]})) * age;
      end
      if (state_ff == ST_R_ADD) begin
         size_lerp_ff <= ppe_pkg::sat32(40'(rd_ff.size) + 40'($signed(sz_prod_ff[50:16])));
         for (int k = 0; k < 4; k++) begin
            if (ch_sum[k] < 12'sd0) ch_ff[k] <= 8'd0;
            else if (ch_sum[k] > 12'sd255) ch_ff[k] <= 8'd255;
            else ch_ff[k] <= ch_sum[k][7:0];
         end
      end
   end

   assign alpha_prod = 25'(ch_ff[0]) * 25'(frac_ff);

   // The slot is the last one when no active slot lies above it.
   always_comb begin
      for (int j = 0; j < POOL_SIZE; j++)
         above_mask[j] = (CNT_W'(j) > idx_ff);
   end
   assign is_last = ((active_ff & above_mask) == '0);

   assign rsp_load = (state_ff == ST_R_OUT) && (!rsp_vld_ff || rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.draw_x <= rd_ff.pos_x;
         rsp_data_ff.draw_y <= rd_ff.pos_y;
         rsp_data_ff.draw_rotation <= rd_ff.rotation;
         rsp_data_ff.draw_size <= size_lerp_ff;
         rsp_data_ff.draw_color <= {ch_ff[3], ch_ff[2], ch_ff[1], alpha_prod[23:16]};
         rsp_data_ff.slot <= ppe_pkg::SLOT_W'(idx_slot);
         rsp_data_ff.last <= is_last;
      end
   end

   assign rsp_chan.valid = rsp_vld_ff;
   assign rsp_chan.payload = rsp_data_ff;
endmodule
`default_nettype wire

>>> rtl/ppe_checker.sv
// Port-level checks of the particle pool engine and their binding to the top level.
`default_nettype none
module ppe_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic [1:0]       req_mode,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire ppe_pkg::rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result word changed while stalled");

   a_render_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> !req_ready)
      else $error("new word taken before the render finished");

   a_item_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == ppe_pkg::MODE_EMIT
         || req_mode == ppe_pkg::MODE_TICK || req_mode == ppe_pkg::MODE_RENDER)
      |=> !req_ready)
      else $error("engine still ready after taking a word");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind particle_pool_engine_top ppe_checker u_ppe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_mode  (req_chan.payload.mode),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.payload)
);
`default_nettype wire
